// ----- rtl/tag_score_argmax_table_assert.svh -----
// Assertion macros used by the tag score table top-level RTL.
`ifndef TAG_SCORE_ARGMAX_TABLE_ASSERT_SVH
`define TAG_SCORE_ARGMAX_TABLE_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define TSA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tag_score_argmax_table: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define TSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tag_score_argmax_table: next-cycle check failed");

`endif

// ----- rtl/tsa_pkg.sv -----
// Shared types and constants for the tag score table.
package tsa_pkg;

    // Port field widths
    localparam int TAG_W        = 8;
    localparam int SCORE_IN_W   = 24;
    localparam int BEST_TAG_W   = 9;
    localparam int BEST_SCORE_W = 25;
    localparam int COUNT_W      = 9;

    // Operation codes
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_DEL = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_SCAN_END,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic acc;       // latch request, read its entry
        logic upd;       // apply the request to the table
        logic scan_rd;   // read entry at the sweep address for the rescan
        logic clr_wr;    // clear entry at the sweep address
        logic out_load;  // load the result register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic need_scan; // best tag was removed, rescan needed
    } t_sts;

endpackage

// ----- rtl/tsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tsa_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tsa_ctrl.sv -----
// Controller: sequences clearing, per-request update, rescan and result handoff.
module tsa_ctrl import tsa_pkg::*; #(
    parameter int TAG_COUNT = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_out_stall,
    input  t_sts                         i_sts,
    output t_cmd                         o_cmd,
    output logic [$clog2(TAG_COUNT)-1:0] o_sweep_addr,
    output logic                         o_in_stall,
    output logic                         o_out_valid
);

    localparam int AW = $clog2(TAG_COUNT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TAG_COUNT - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_out_valid, n_out_valid;
    logic          out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // State, sweep counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.acc = 1'b1;
                    n_state   = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.upd = 1'b1;
                if (i_sts.need_scan) begin
                    n_addr  = '0;
                    n_state = S_SCAN;
                end else if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = S_SCAN_END;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_SCAN_END: begin
                // last read entry folds into the best this cycle
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load || (r_out_valid && i_out_stall);
    end

    assign o_sweep_addr = r_addr;
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;

endmodule

// ----- rtl/tsa_dp.sv -----
// Datapath: score table, running best, present count and result register.
module tsa_dp import tsa_pkg::*; #(
    parameter int TAG_COUNT  = 256,
    parameter int SCORE_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    input  logic [$clog2(TAG_COUNT)-1:0]   i_sweep_addr,
    input  logic                           i_op,
    input  logic [TAG_W-1:0]               i_tag,
    input  logic [SCORE_IN_W-1:0]          i_score,
    output t_sts                           o_sts,
    output logic signed [BEST_TAG_W-1:0]   o_best_tag,
    output logic signed [BEST_SCORE_W-1:0] o_best_score,
    output logic [COUNT_W-1:0]             o_tag_count,
    output logic                           o_status
);

    localparam int AW   = $clog2(TAG_COUNT);
    localparam int CNTW = $clog2(TAG_COUNT + 1);
    localparam int EW   = SCORE_BITS + 1;
    localparam int CW   = (SCORE_BITS > SCORE_IN_W) ? SCORE_BITS : SCORE_IN_W;
    localparam logic [SCORE_BITS-1:0] SMAX = '1;

    // Latched request
    logic                  r_op;
    logic [TAG_W-1:0]      r_tag;
    logic [SCORE_IN_W-1:0] r_score;

    // Running best and count
    logic                  r_best_vld, n_best_vld;
    logic [AW-1:0]         r_best_tag, n_best_tag;
    logic [SCORE_BITS-1:0] r_best_score, n_best_score;
    logic [CNTW-1:0]       r_count, n_count;
    logic                  r_status, n_status;

    // Rescan read tracking
    logic                  r_scan_vld;
    logic [AW-1:0]         r_scan_addr;

    // Result register
    logic signed [BEST_TAG_W-1:0]   r_o_best_tag;
    logic signed [BEST_SCORE_W-1:0] r_o_best_score;
    logic [COUNT_W-1:0]             r_o_tag_count;
    logic                           r_o_status;

    // RAM access
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    // Update arithmetic
    logic                  tag_ok, is_add, rd_present;
    logic [AW-1:0]         upd_addr;
    logic [SCORE_BITS-1:0] rd_score, sc_sat, total;
    logic [SCORE_BITS:0]   sum;
    logic                  add_wins, scan_wins;

    tsa_ram #(
        .WIDTH (EW),
        .DEPTH (TAG_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Decode the latched request against the read entry
    always_comb begin
        tag_ok     = 32'(r_tag) < TAG_COUNT;
        is_add     = (r_op == OP_ADD);
        upd_addr   = AW'(r_tag);
        rd_present = ram_rdata[SCORE_BITS];
        rd_score   = ram_rdata[SCORE_BITS-1:0];
        sc_sat     = (CW'(r_score) > CW'(SMAX)) ? SMAX : SCORE_BITS'(r_score);
        sum        = {1'b0, rd_score} + {1'b0, sc_sat};
        if (rd_present) begin
            total = sum[SCORE_BITS] ? SMAX : sum[SCORE_BITS-1:0];
        end else begin
            total = sc_sat;
        end
        add_wins  = !r_best_vld || (total > r_best_score) ||
                    ((total == r_best_score) && (upd_addr > r_best_tag));
        scan_wins = r_scan_vld && rd_present &&
                    (!r_best_vld || (rd_score >= r_best_score));
    end

    assign o_sts.need_scan = i_cmd.upd && !is_add && tag_ok && rd_present &&
                             r_best_vld && (r_best_tag == upd_addr);

    // Table port steering
    always_comb begin
        ram_re    = i_cmd.acc || i_cmd.scan_rd;
        ram_raddr = i_cmd.acc ? AW'(i_tag) : i_sweep_addr;
        ram_we    = i_cmd.clr_wr || (i_cmd.upd && tag_ok && (is_add || rd_present));
        ram_waddr = i_cmd.clr_wr ? i_sweep_addr : upd_addr;
        if (!i_cmd.clr_wr && is_add) begin
            ram_wdata = {1'b1, total};
        end else begin
            ram_wdata = '0;
        end
    end

    // Next best, count and status
    always_comb begin
        n_best_vld   = r_best_vld;
        n_best_tag   = r_best_tag;
        n_best_score = r_best_score;
        n_count      = r_count;
        n_status     = r_status;
        if (i_cmd.upd) begin
            n_status = !is_add && !(tag_ok && rd_present);
            if (tag_ok && is_add) begin
                if (!rd_present) begin
                    n_count = r_count + 1'b1;
                end
                if (add_wins) begin
                    n_best_vld   = 1'b1;
                    n_best_tag   = upd_addr;
                    n_best_score = total;
                end
            end else if (tag_ok && rd_present) begin
                n_count = r_count - 1'b1;
                if (o_sts.need_scan) begin
                    n_best_vld = 1'b0;
                end
            end
        end else if (scan_wins) begin
            n_best_vld   = 1'b1;
            n_best_tag   = r_scan_addr;
            n_best_score = rd_score;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_vld <= 1'b0;
            r_count    <= '0;
            r_scan_vld <= 1'b0;
        end else begin
            r_best_vld <= n_best_vld;
            r_count    <= n_count;
            r_scan_vld <= i_cmd.scan_rd;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_op    <= i_op;
            r_tag   <= i_tag;
            r_score <= i_score;
        end
        r_best_tag   <= n_best_tag;
        r_best_score <= n_best_score;
        r_status     <= n_status;
        r_scan_addr  <= i_sweep_addr;
        if (i_cmd.out_load) begin
            r_o_best_tag   <= n_best_vld ? BEST_TAG_W'(n_best_tag) : '1;
            r_o_best_score <= n_best_vld ? BEST_SCORE_W'(n_best_score) : '1;
            r_o_tag_count  <= COUNT_W'(n_count);
            r_o_status     <= n_status;
        end
    end

    assign o_best_tag   = r_o_best_tag;
    assign o_best_score = r_o_best_score;
    assign o_tag_count  = r_o_tag_count;
    assign o_status     = r_o_status;

endmodule

// ----- rtl/tag_score_argmax_table.sv -----
// Each add or delete reads its table entry on acceptance, then applies the update in
// S_UPDATE and loads the result there, or in S_DONE after a rescan or a stalled output.
// Stall stays high outside S_IDLE, so no new request is taken until the last is done.
// Deleting the current best tag rescans every entry through the RAM read port.
// Reset: synchronous; a clearing sweep of every entry follows, with stall held high.
module tag_score_argmax_table import tsa_pkg::*; #(
    parameter int TAG_COUNT  = 256,
    parameter int SCORE_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_op,
    input  logic [TAG_W-1:0]               i_tag,
    input  logic [SCORE_IN_W-1:0]          i_score,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [BEST_TAG_W-1:0]   o_best_tag,
    output logic signed [BEST_SCORE_W-1:0] o_best_score,
    output logic [COUNT_W-1:0]             o_tag_count,
    output logic                           o_status
);

    `include "tag_score_argmax_table_assert.svh"

    t_cmd                         cmd;
    t_sts                         sts;
    logic [$clog2(TAG_COUNT)-1:0] sweep_addr;

    tsa_ctrl #(
        .TAG_COUNT (TAG_COUNT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_out_stall  (i_out_stall),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_sweep_addr (sweep_addr),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid)
    );

    tsa_dp #(
        .TAG_COUNT  (TAG_COUNT),
        .SCORE_BITS (SCORE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_sweep_addr (sweep_addr),
        .i_op         (i_op),
        .i_tag        (i_tag),
        .i_score      (i_score),
        .o_sts        (sts),
        .o_best_tag   (o_best_tag),
        .o_best_score (o_best_score),
        .o_tag_count  (o_tag_count),
        .o_status     (o_status)
    );

    // An accepted request holds off the next one while it is processed
    `TSA_ASSERT_NEXT(a_accept_blocks, i_in_valid && !o_in_stall, o_in_stall)
    // An empty table reports no best tag and no best score
    `TSA_ASSERT_SAME(a_empty_best, o_out_valid && (o_tag_count == '0),
                     (o_best_tag == '1) && (o_best_score == '1))
    // A non-empty table always reports a best tag
    `TSA_ASSERT_SAME(a_best_present, o_out_valid && (o_tag_count != '0), o_best_tag != '1)
    // The count never exceeds the table size
    `TSA_ASSERT_SAME(a_count_range, o_out_valid, 32'(o_tag_count) <= TAG_COUNT)

endmodule

// ----- bench/tag_score_argmax_table_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the tag score argmax table: predicted table views against DUT results.
module tag_score_argmax_table_tb import tsa_pkg::*; ();

    localparam int NUM_TAGS       = 256;
    localparam int SCORE_BITS     = 24;
    localparam int DRAIN_CYCLES   = NUM_TAGS + 16;
    localparam int HOLDOFF_CYCLES = 400;
    localparam logic [SCORE_IN_W-1:0] SCORE_MAX = {SCORE_IN_W{1'b1}};

    // Table view reported after one request
    typedef struct packed {
        logic [BEST_TAG_W-1:0]   best_tag;
        logic [BEST_SCORE_W-1:0] best_score;
        logic [COUNT_W-1:0]      tag_count;
        logic                    status;
    } t_table_view;

    class t_argmax_scoreboard;
        logic [SCORE_IN_W-1:0]          tag_scores [NUM_TAGS];
        bit                             present [NUM_TAGS];
        logic signed [BEST_TAG_W-1:0]   best_tag;
        logic signed [BEST_SCORE_W-1:0] best_score;
        logic [COUNT_W-1:0]             present_total;
        t_table_view                    expected_views [$];
        int mismatches;
        int results_seen;
        int adds;
        int deletes;
        int absent_deletes;
        int rescans;
        int peak_total;

        function new();
            foreach (tag_scores[t]) begin
                tag_scores[t] = '0;
                present[t]    = 1'b0;
            end
            best_tag       = '1;
            best_score     = '1;
            present_total  = '0;
            mismatches     = 0;
            results_seen   = 0;
            adds           = 0;
            deletes        = 0;
            absent_deletes = 0;
            rescans        = 0;
            peak_total     = 0;
        endfunction

        // Sweep all present tags; later (larger) tags win ties
        function void rescan_best();
            best_tag   = '1;
            best_score = '1;
            rescans++;
            for (int t = 0; t < NUM_TAGS; t++) begin
                if (present[t] && $signed({1'b0, tag_scores[t]}) >= best_score) begin
                    best_score = {1'b0, tag_scores[t]};
                    best_tag   = BEST_TAG_W'(t);
                end
            end
        endfunction

        // Apply an accepted request and queue the table view it must produce
        function void note_request(logic op, logic [TAG_W-1:0] tag,
                                   logic [SCORE_IN_W-1:0] score);
            logic [SCORE_IN_W:0]   sum;
            logic [SCORE_IN_W-1:0] total;
            logic                  status;
            status = 1'b0;
            if (op == OP_ADD) begin
                adds++;
                if (present[tag]) begin
                    sum   = {1'b0, tag_scores[tag]} + {1'b0, score};
                    total = sum[SCORE_IN_W] ? SCORE_MAX : sum[SCORE_IN_W-1:0];
                end else begin
                    present[tag]  = 1'b1;
                    present_total = present_total + 1'b1;
                    total         = score;
                end
                tag_scores[tag] = total;
                // Take the lead on a higher score, or on an equal score with a larger tag
                if ($signed({1'b0, total}) > best_score ||
                    ($signed({1'b0, total}) == best_score &&
                     $signed({1'b0, tag}) > best_tag)) begin
                    best_score = {1'b0, total};
                    best_tag   = {1'b0, tag};
                end
            end else begin
                deletes++;
                if (present[tag]) begin
                    present[tag]    = 1'b0;
                    tag_scores[tag] = '0;
                    present_total   = present_total - 1'b1;
                    if (best_tag == $signed({1'b0, tag}))
                        rescan_best();
                end else begin
                    status = 1'b1;
                    absent_deletes++;
                end
            end
            if (int'(present_total) > peak_total)
                peak_total = int'(present_total);
            expected_views.push_back('{best_tag, best_score, present_total, status});
        endfunction

        // Compare one result with the oldest expected view
        function void check_result(t_table_view seen);
            t_table_view want;
            results_seen++;
            if (expected_views.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: unexpected result: best_tag %0d best_score %0d",
                              " count %0d status %0d"},
                             $signed(seen.best_tag), $signed(seen.best_score),
                             seen.tag_count, seen.status);
                return;
            end
            want = expected_views.pop_front();
            if (seen.best_tag !== want.best_tag || seen.best_score !== want.best_score ||
                seen.tag_count !== want.tag_count || seen.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result %0d: best_tag exp %0d got %0d, best_score exp %0d",
                              " got %0d, count exp %0d got %0d, status exp %0d got %0d"},
                             results_seen, $signed(want.best_tag), $signed(seen.best_tag),
                             $signed(want.best_score), $signed(seen.best_score),
                             want.tag_count, seen.tag_count, want.status, seen.status);
            end
        endfunction
    endclass

    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_in_valid   = 1'b0;
    logic                           i_op         = OP_ADD;
    logic [TAG_W-1:0]               i_tag        = '0;
    logic [SCORE_IN_W-1:0]          i_score      = '0;
    logic                           i_out_stall  = 1'b0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic signed [BEST_TAG_W-1:0]   o_best_tag;
    logic signed [BEST_SCORE_W-1:0] o_best_score;
    logic [COUNT_W-1:0]             o_tag_count;
    logic                           o_status;

    t_argmax_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holdoff_asked  = 0;
    int holdoff_served = 0;
    int holdoff_left   = 0;

    tag_score_argmax_table #(
        .TAG_COUNT  (NUM_TAGS),
        .SCORE_BITS (SCORE_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_tag        (i_tag),
        .i_score      (i_score),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_best_tag   (o_best_tag),
        .o_best_score (o_best_score),
        .o_tag_count  (o_tag_count),
        .o_status     (o_status)
    );

    // Free-running clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result('{o_best_tag, o_best_score, o_tag_count, o_status});
    end

    // Drive the result-side stall, with occasional long hold-offs
    always @(posedge i_clk) begin
        if (holdoff_left == 0 && holdoff_served != holdoff_asked) begin
            holdoff_served++;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one request, idling first at random, and hold it until accepted
    task automatic send_request(input logic op, input logic [TAG_W-1:0] tag,
                                input logic [SCORE_IN_W-1:0] score);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_tag      <= tag;
        i_score    <= score;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_request(op, tag, score);
    endtask

    // Mix tiny, full-range and near-saturation scores so ties and overflow both occur
    function automatic logic [SCORE_IN_W-1:0] random_score();
        case ($urandom_range(3))
            0:       return SCORE_IN_W'($urandom_range(15));
            1:       return SCORE_IN_W'($urandom);
            2:       return SCORE_MAX - SCORE_IN_W'($urandom_range(15));
            default: return SCORE_IN_W'($urandom_range(4095));
        endcase
    endfunction

    // Random add or delete, biased toward a small tag pool and toward the current best
    task automatic random_request();
        int               pick;
        logic [TAG_W-1:0] tag;
        pick = $urandom_range(99);
        if ($urandom_range(1))
            tag = TAG_W'($urandom_range(15));
        else
            tag = TAG_W'($urandom);
        if (pick < 60)
            send_request(OP_ADD, tag, random_score());
        else if (pick < 78 && sb.best_tag >= 0)
            send_request(OP_DEL, sb.best_tag[TAG_W-1:0], random_score());
        else
            send_request(OP_DEL, tag, random_score());
    endtask

    // Guard against a hung block
    initial begin
        #15_000_000;
        $display("Timeout with %0d results still pending", sb.expected_views.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, ties, saturation, rescans down to empty
        send_request(OP_DEL, 8'd5,   24'd0);
        send_request(OP_ADD, 8'd0,   24'd0);
        send_request(OP_ADD, 8'd255, 24'd0);
        send_request(OP_ADD, 8'd3,   SCORE_MAX);
        send_request(OP_ADD, 8'd3,   24'd1);
        send_request(OP_ADD, 8'd200, SCORE_MAX);
        send_request(OP_ADD, 8'd0,   24'h555555);
        send_request(OP_ADD, 8'd0,   24'hAAAAAA);
        send_request(OP_DEL, 8'd200, SCORE_MAX);
        send_request(OP_DEL, 8'd3,   24'd0);
        send_request(OP_DEL, 8'd7,   24'd0);
        send_request(OP_ADD, 8'd128, 24'h800000);
        send_request(OP_ADD, 8'd128, 24'h7FFFFF);
        send_request(OP_ADD, 8'd128, 24'h000001);
        send_request(OP_DEL, 8'd255, 24'd0);
        send_request(OP_DEL, 8'd255, 24'd0);
        send_request(OP_DEL, 8'd0,   24'd0);
        send_request(OP_DEL, 8'd128, 24'd0);
        send_request(OP_DEL, 8'd128, 24'd0);
        send_request(OP_ADD, 8'd1,   24'h000001);
        send_request(OP_ADD, 8'd254, 24'h7FFFFF);
        send_request(OP_DEL, 8'd254, 24'd0);
        send_request(OP_DEL, 8'd1,   24'd0);

        // Random mix, no idling
        repeat (250) random_request();

        // Fill every tag, then peel off the best repeatedly; sender idles often
        send_idle_pct = 79;
        for (int t = 0; t < NUM_TAGS; t++)
            send_request(OP_ADD, TAG_W'(t), random_score());
        repeat (40) send_request(OP_DEL, sb.best_tag[TAG_W-1:0], random_score());

        // Random mix against a slow receiver
        send_idle_pct  = 0;
        recv_stall_pct = 79;
        repeat (300) random_request();

        // Drain the whole table in order, then random, both sides idling lightly
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        for (int t = 0; t < NUM_TAGS; t++)
            send_request(OP_DEL, TAG_W'(t), SCORE_IN_W'($urandom));
        repeat (200) random_request();

        // Hold the receiver off while requests keep coming, then run flat out
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_asked++;
        repeat (226) random_request();
        i_in_valid <= 1'b0;

        // Wait for the last results, then give any stray output time to show up
        while (sb.expected_views.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d results from %0d adds and %0d deletes, %0d on absent tags.",
                 sb.results_seen, sb.adds, sb.deletes, sb.absent_deletes);
        $display("Best-tag rescans: %0d; peak tag count %0d; mismatches %0d.",
                 sb.rescans, sb.peak_total, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_views.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
